>>> rtl/mapn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mapn_pkg
// Shared constants and types for the moving-average peak normalizer.
// ----------------------------------------------------------------------------
package mapn_pkg;

    localparam int WINDOW_DEFAULT      = 25;
    localparam int SAMPLE_BITS_DEFAULT = 12;

    localparam int          REG_BITS      = 16;
    localparam int          CFG_ADDR_BITS = 1;
    localparam logic [15:0] GAIN_RESET    = 16'd8000;
    localparam logic [15:0] PWM_TOP_RESET = 16'd18000;

    localparam logic [CFG_ADDR_BITS-1:0] REG_GAIN    = 1'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_PWM_TOP = 1'd1;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef enum logic [6:0] {
        ST_IDLE       = 7'b0000001,
        ST_FETCH      = 7'b0000010,
        ST_MEAN       = 7'b0000100,
        ST_SCALE      = 7'b0001000,
        ST_SCALE_WAIT = 7'b0010000,
        ST_EMIT       = 7'b0100000,
        ST_SPARE      = 7'b1000000
    } state_t;

endpackage

>>> rtl/mapn_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mapn_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mapn_divider
    import mapn_pkg::*;
#(
    parameter int DIVIDEND_W = 28,
    parameter int DIVISOR_W  = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0] quotient,
    output div_status_t           status
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dsr_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign trial   = shifted - {1'b0, dsr_reg};
    assign fits    = (shifted >= {1'b0, dsr_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
            rem_reg <= fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

>>> rtl/moving_average_peak_normalizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moving_average_peak_normalizer
// The level mean*gain/peak comes from the one-bit-per-cycle divider; while peak
// is 0 the divider is skipped and the level is 0.
// A new request is taken only once the last one has reached the output register;
// the next request is taken while the result waits in the output register.
// Reset: synchronous active-low; ring valid bits, total, peak, slot cleared.
// ----------------------------------------------------------------------------
module moving_average_peak_normalizer
    import mapn_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEFAULT,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [CFG_ADDR_BITS-1:0]           cfg_addr,
    input  logic [REG_BITS-1:0]                cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,   // sample_value
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [15:0]                        m_tdata    // duty_value
);

    localparam int SLOT_W      = $clog2(WINDOW);
    localparam int TOTAL_BITS  = SAMPLE_BITS + $clog2(WINDOW);
    localparam int DIVIDEND_W  = SAMPLE_BITS + REG_BITS;
    localparam int RECIP_SHIFT = TOTAL_BITS + $clog2(WINDOW);
    localparam int RECIP_BITS  = TOTAL_BITS + 1;
    // total / WINDOW by reciprocal multiply, exact over the whole total range
    localparam logic [RECIP_BITS-1:0] MEAN_RECIP =
        RECIP_BITS'(((2 ** RECIP_SHIFT) + WINDOW - 1) / WINDOW);

    state_t state_reg, state_next;

    logic [REG_BITS-1:0]    gain_reg;
    logic [REG_BITS-1:0]    pwm_top_reg;
    logic [SAMPLE_BITS-1:0] ring [WINDOW];
    logic [WINDOW-1:0]      valid_reg;
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic                   rd_valid_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [TOTAL_BITS-1:0]  total_reg;
    logic [TOTAL_BITS-1:0]  total_next;
    logic [SAMPLE_BITS-1:0] peak_reg;
    logic [SAMPLE_BITS-1:0] mean_reg;
    logic [REG_BITS-1:0]    level_reg;
    logic                   m_tvalid_reg;
    logic [15:0]            m_tdata_reg;
    logic [15:0]            duty;
    logic [SAMPLE_BITS-1:0] old_sample;
    logic [TOTAL_BITS+RECIP_BITS-1:0] mean_prod;

    logic                   in_accept;
    logic                   out_free;
    logic                   div_start;
    logic [DIVIDEND_W-1:0]  div_dividend;
    logic [SAMPLE_BITS-1:0] div_divisor;
    logic [DIVIDEND_W-1:0]  div_quotient;
    div_status_t            div_stat;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign old_sample = rd_valid_reg ? rd_data_reg : '0;
    assign total_next = total_reg - TOTAL_BITS'(old_sample) + TOTAL_BITS'(sample_reg);
    assign mean_prod  = total_reg * MEAN_RECIP;
    assign duty = (level_reg > pwm_top_reg) ? 16'd0 : (pwm_top_reg - level_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg    <= GAIN_RESET;
            pwm_top_reg <= PWM_TOP_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_GAIN:    gain_reg    <= cfg_wdata;
                REG_PWM_TOP: pwm_top_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ring storage
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            rd_data_reg <= ring[slot_reg];
        end
        if (state_reg == ST_FETCH) begin
            ring[slot_reg] <= sample_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (in_accept) begin
                rd_valid_reg <= valid_reg[slot_reg];
            end
            if (state_reg == ST_FETCH) begin
                valid_reg[slot_reg] <= 1'b1;
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        div_start    = 1'b0;
        div_dividend = DIVIDEND_W'(mean_reg * gain_reg);
        div_divisor  = peak_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                state_next = ST_MEAN;
            end
            ST_MEAN: begin
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                if (peak_reg == '0) begin
                    state_next = ST_EMIT;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_SCALE_WAIT;
                end
            end
            ST_SCALE_WAIT: begin
                if (div_stat.done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            slot_reg     <= '0;
            total_reg    <= '0;
            peak_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_FETCH) begin
                total_reg <= total_next;
                if (sample_reg > peak_reg) begin
                    peak_reg <= sample_reg;
                end
                slot_reg <= (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
            end
            if (state_reg == ST_EMIT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            sample_reg <= s_tdata[SAMPLE_BITS-1:0];
        end
        if (state_reg == ST_MEAN) begin
            mean_reg <= mean_prod[RECIP_SHIFT +: SAMPLE_BITS];
        end
        if (state_reg == ST_SCALE) begin
            level_reg <= '0;
        end
        if (state_reg == ST_SCALE_WAIT && div_stat.done) begin
            level_reg <= div_quotient[REG_BITS-1:0];
        end
        if (state_reg == ST_EMIT && out_free) begin
            m_tdata_reg <= duty;
        end
    end

    mapn_divider #(
        .DIVIDEND_W (DIVIDEND_W),
        .DIVISOR_W  (SAMPLE_BITS)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .status   (div_stat)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_accept_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> state_reg == ST_FETCH)
        else $error("request not followed by ring fetch");

    a_div_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> level_reg <= gain_reg)
        else $error("level exceeds gain");

    a_duty_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> m_tdata_reg <= pwm_top_reg)
        else $error("duty exceeds full scale");

endmodule
